[src/assert_macros.svh]
// Assertion macros used by the signature engine controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define DSA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition a implies condition b in the cycle after.
`define DSA_ASSERT_NEXT(name, a, b, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

[src/dsa_pkg.sv]
// Shared types and constants of the DSA sign and verify engine.
`default_nettype none
package dsa_pkg;

  localparam int FIELD_W      = 16;
  localparam int CODE_W       = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int MOD_BITS_DEF = 16;

  localparam logic [FIELD_W-1:0] P_RESET = 16'd23;
  localparam logic [FIELD_W-1:0] Q_RESET = 16'd11;
  localparam logic [FIELD_W-1:0] G_RESET = 16'd5;
  localparam logic [FIELD_W-1:0] X_RESET = 16'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P = 2'd0,
    CFG_Q = 2'd1,
    CFG_G = 2'd2,
    CFG_X = 2'd3
  } cfg_idx_t;

  typedef enum logic [CODE_W-1:0] {
    OC_VALID    = 3'd0,
    OC_MISMATCH = 3'd1,
    OC_R_ZERO   = 3'd2,
    OC_K_BAD    = 3'd3,
    OC_S_ZERO   = 3'd4,
    OC_S_NOINV  = 3'd5
  } outcome_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_LDE,
    OP_SHE,
    OP_ADD,
    OP_INV_INIT,
    OP_DIV,
    OP_INV_STEP,
    OP_INV_END,
    OP_MVY,
    OP_MVV
  } op_t;

  typedef enum logic [3:0] {
    SEL_ONE,
    SEL_ACC,
    SEL_B,
    SEL_G,
    SEL_Y,
    SEL_H,
    SEL_X,
    SEL_R,
    SEL_S,
    SEL_KI,
    SEL_QT,
    SEL_T1,
    SEL_V,
    SEL_K,
    SEL_U1,
    SEL_U2
  } sel_t;

  typedef enum logic [2:0] {
    DST_ACC,
    DST_B,
    DST_R,
    DST_S,
    DST_T,
    DST_U1,
    DST_U2,
    DST_V
  } dst_t;

  typedef struct packed {
    op_t  op;
    sel_t a_sel;
    sel_t b_sel;
    logic m_q;
    dst_t dst;
    logic fin;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic busy;
    logic e_lsb;
    logic r1_zero;
    logic r0_one;
    logic r_zero;
    logic s_zero;
    logic k_bad;
    logic v_eq_r;
  } stat_t;

endpackage
`default_nettype wire

[src/dsa_if.sv]
// Request channel interfaces of the DSA engine.
`default_nettype none
interface dsa_in_if;
  logic                        valid;
  logic                        ready;
  logic [dsa_pkg::FIELD_W-1:0] message_hash;
  logic [dsa_pkg::FIELD_W-1:0] nonce;
  modport source (output valid, output message_hash, output nonce, input ready);
  modport sink (input valid, input message_hash, input nonce, output ready);
endinterface

interface dsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [dsa_pkg::FIELD_W-1:0] sig_r;
  logic [dsa_pkg::FIELD_W-1:0] sig_s;
  logic [dsa_pkg::CODE_W-1:0]  outcome;
  modport source (output valid, output sig_r, output sig_s, output outcome, input ready);
  modport sink (input valid, input sig_r, input sig_s, input outcome, output ready);
endinterface
`default_nettype wire

[src/dsa_sign_verify_top.sv]
// Top level of the small-modulus DSA sign and verify engine.
// The engine signs one request at a time and checks its own signature.
// in_ch carries message_hash and nonce; out_ch returns sig_r, sig_s and
// outcome (0 valid, 1 mismatch, 2 r zero, 3 bad nonce, 4 s zero, 5 s not
// invertible). Both channels use valid/ready; a request moves when both
// are high. p, q, g and x are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the engine is idle (not enforced).
// Every modular product runs on one shared bit-serial multiply-reduce unit,
// and each Euclid step of an inverse is a bit-serial divide plus one
// product. An exponentiation scans all MOD_BITS exponent bits, squaring
// for each and multiplying in for each set bit. A request that fails on r
// or on an out-of-range nonce ends before any inverse is started.
// A new request is taken once the previous one is finished; the result sits
// in an output register, so computing continues while the receiver stalls
// and only the hand-off of the next result waits for it.
// Synchronous reset returns the registers to p=23, q=11, g=5, x=6 and
// drops any request in flight.
`default_nettype none
module dsa_sign_verify_top #(
  parameter int MOD_BITS = dsa_pkg::MOD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  dsa_in_if.sink                             in_ch,
  dsa_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dsa_pkg::FIELD_W-1:0]   cfg_data
);

  localparam int FW = dsa_pkg::FIELD_W;

  dsa_pkg::cmd_t     cmd;
  dsa_pkg::stat_t    st;
  dsa_pkg::outcome_t code;
  logic [MOD_BITS-1:0] r_val, s_val;

  logic          out_valid;
  logic [FW-1:0] out_r, out_s;
  dsa_pkg::outcome_t out_code;
  logic          out_free, out_load;

  assign out_free = !out_valid || out_ch.ready;
  assign out_load = cmd.fin && out_free;

  dsa_ctrl #(.MOD_BITS(MOD_BITS)) u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .st   (st),
    .cmd  (cmd),
    .code (code)
  );

  dsa_dp #(.MOD_BITS(MOD_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .h_in      (MOD_BITS'(in_ch.message_hash)),
    .k_in      (MOD_BITS'(in_ch.nonce)),
    .in_valid  (in_ch.valid),
    .out_free  (out_free),
    .st        (st),
    .r_val     (r_val),
    .s_val     (s_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r    <= FW'(r_val);
      out_s    <= FW'(s_val);
      out_code <= code;
    end
  end

  assign in_ch.ready    = cmd.in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.sig_r   = out_r;
  assign out_ch.sig_s   = out_s;
  assign out_ch.outcome = out_code;

endmodule
`default_nettype wire

[src/dsa_dp.sv]
// Datapath: configuration, working registers, bit-serial modular multiplier and divider.
`default_nettype none
module dsa_dp #(
  parameter int MOD_BITS = dsa_pkg::MOD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire dsa_pkg::cmd_t                  cmd,
  input  wire logic                           cfg_we,
  input  wire logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dsa_pkg::FIELD_W-1:0]    cfg_data,
  input  wire logic [MOD_BITS-1:0]            h_in,
  input  wire logic [MOD_BITS-1:0]            k_in,
  input  wire logic                           in_valid,
  input  wire logic                           out_free,
  output dsa_pkg::stat_t                      st,
  output logic [MOD_BITS-1:0]                 r_val,
  output logic [MOD_BITS-1:0]                 s_val
);

  localparam int N  = MOD_BITS;
  localparam int CW = $clog2(N);
  localparam logic [CW-1:0] LAST = CW'(N - 1);
  localparam logic [N-1:0]  ONE  = N'(1);

  logic [N-1:0] cp, cq, cg, cx;
  logic [N-1:0] h, k, e, acc, b, r, s, t, ki, u1, u2, y, v;
  logic [N-1:0] r0, r1, t0, t1, qt, rem;

  // Multiplier engine
  logic [N-1:0]    ma, mb, mm, macc;
  logic [CW-1:0]   mcnt;
  logic            mbusy;
  dsa_pkg::dst_t   mdst;
  logic [N:0]      dbl, dbl_r, add, add_r;
  logic [N-1:0]    macc_next, mres;

  // Divider engine
  logic [N-1:0]    dn, dd, drem, dquo;
  logic [CW-1:0]   dcnt;
  logic            dbusy;
  logic [N:0]      dsh;
  logic            dqbit;
  logic [N-1:0]    drem_next, dquo_next;

  logic [N-1:0]    a_val, b_val;
  logic [N:0]      sum;

  always_comb begin
    case (cmd.a_sel)
      dsa_pkg::SEL_ONE: a_val = ONE;
      dsa_pkg::SEL_ACC: a_val = acc;
      dsa_pkg::SEL_B:   a_val = b;
      dsa_pkg::SEL_G:   a_val = cg;
      dsa_pkg::SEL_Y:   a_val = y;
      dsa_pkg::SEL_H:   a_val = h;
      dsa_pkg::SEL_X:   a_val = cx;
      dsa_pkg::SEL_R:   a_val = r;
      dsa_pkg::SEL_S:   a_val = s;
      dsa_pkg::SEL_KI:  a_val = ki;
      dsa_pkg::SEL_QT:  a_val = qt;
      dsa_pkg::SEL_T1:  a_val = t1;
      dsa_pkg::SEL_V:   a_val = v;
      dsa_pkg::SEL_K:   a_val = k;
      dsa_pkg::SEL_U1:  a_val = u1;
      dsa_pkg::SEL_U2:  a_val = u2;
      default:          a_val = '0;
    endcase
  end

  always_comb begin
    case (cmd.b_sel)
      dsa_pkg::SEL_ONE: b_val = ONE;
      dsa_pkg::SEL_ACC: b_val = acc;
      dsa_pkg::SEL_B:   b_val = b;
      dsa_pkg::SEL_R:   b_val = r;
      dsa_pkg::SEL_S:   b_val = s;
      dsa_pkg::SEL_KI:  b_val = ki;
      dsa_pkg::SEL_T1:  b_val = t1;
      dsa_pkg::SEL_V:   b_val = v;
      default:          b_val = '0;
    endcase
  end

  // One step of interleaved multiply-reduce: acc = 2*acc + bit*b, kept below m.
  always_comb begin
    dbl       = {macc, 1'b0};
    dbl_r     = (dbl >= {1'b0, mm}) ? dbl - {1'b0, mm} : dbl;
    add       = dbl_r + (ma[N-1] ? {1'b0, mb} : '0);
    add_r     = (add >= {1'b0, mm}) ? add - {1'b0, mm} : add;
    macc_next = add_r[N-1:0];
    // Reduction modulo 0 or 1 gives 0.
    mres      = (mm[N-1:1] == '0) ? '0 : macc_next;
  end

  // One step of restoring division.
  always_comb begin
    dsh       = {drem, dn[N-1]};
    dqbit     = (dsh >= {1'b0, dd});
    drem_next = dqbit ? N'(dsh - {1'b0, dd}) : dsh[N-1:0];
    dquo_next = {dquo[N-2:0], dqbit};
  end

  assign sum = {1'b0, s} + {1'b0, t};

  always_ff @(posedge clk) begin
    if (rst) begin
      cp    <= N'(dsa_pkg::P_RESET);
      cq    <= N'(dsa_pkg::Q_RESET);
      cg    <= N'(dsa_pkg::G_RESET);
      cx    <= N'(dsa_pkg::X_RESET);
      mbusy <= 1'b0;
      dbusy <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (dsa_pkg::cfg_idx_t'(cfg_index))
          dsa_pkg::CFG_P: cp <= N'(cfg_data);
          dsa_pkg::CFG_Q: cq <= N'(cfg_data);
          dsa_pkg::CFG_G: cg <= N'(cfg_data);
          dsa_pkg::CFG_X: cx <= N'(cfg_data);
        endcase
      end

      if (cmd.op == dsa_pkg::OP_MUL) begin
        mbusy <= 1'b1;
      end else if (mbusy && mcnt == LAST) begin
        mbusy <= 1'b0;
      end

      if (cmd.op == dsa_pkg::OP_DIV) begin
        dbusy <= 1'b1;
      end else if (dbusy && dcnt == LAST) begin
        dbusy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mbusy) begin
      ma   <= {ma[N-2:0], 1'b0};
      macc <= macc_next;
      mcnt <= mcnt + CW'(1);
      if (mcnt == LAST) begin
        case (mdst)
          dsa_pkg::DST_ACC: acc <= mres;
          dsa_pkg::DST_B:   b   <= mres;
          dsa_pkg::DST_R:   r   <= mres;
          dsa_pkg::DST_S:   s   <= mres;
          dsa_pkg::DST_T:   t   <= mres;
          dsa_pkg::DST_U1:  u1  <= mres;
          dsa_pkg::DST_U2:  u2  <= mres;
          dsa_pkg::DST_V:   v   <= mres;
          default:          acc <= mres;
        endcase
      end
    end

    if (dbusy) begin
      dn   <= {dn[N-2:0], 1'b0};
      drem <= drem_next;
      dquo <= dquo_next;
      dcnt <= dcnt + CW'(1);
      if (dcnt == LAST) begin
        qt  <= dquo_next;
        rem <= drem_next;
      end
    end

    case (cmd.op)
      dsa_pkg::OP_LOAD: begin
        h <= h_in;
        k <= k_in;
        s <= '0;
      end
      dsa_pkg::OP_MUL: begin
        ma   <= a_val;
        mb   <= b_val;
        mm   <= cmd.m_q ? cq : cp;
        macc <= '0;
        mcnt <= '0;
        mdst <= cmd.dst;
      end
      dsa_pkg::OP_LDE: e <= a_val;
      dsa_pkg::OP_SHE: e <= {1'b0, e[N-1:1]};
      dsa_pkg::OP_ADD: s <= (sum >= {1'b0, cq}) ? N'(sum - {1'b0, cq}) : sum[N-1:0];
      dsa_pkg::OP_INV_INIT: begin
        r0 <= cq;
        r1 <= a_val;
        t0 <= '0;
        t1 <= ONE;
      end
      dsa_pkg::OP_DIV: begin
        dn   <= r0;
        dd   <= r1;
        drem <= '0;
        dquo <= '0;
        dcnt <= '0;
      end
      dsa_pkg::OP_INV_STEP: begin
        r0 <= r1;
        r1 <= rem;
        t0 <= t1;
        // Coefficients are kept modulo q, so the wrap below is exact.
        t1 <= (t0 >= t) ? t0 - t : t0 + cq - t;
      end
      dsa_pkg::OP_INV_END: ki <= t0;
      dsa_pkg::OP_MVY:     y  <= acc;
      dsa_pkg::OP_MVV:     v  <= acc;
      default: ;
    endcase
  end

  always_comb begin
    st.in_valid = in_valid;
    st.out_free = out_free;
    st.busy     = mbusy | dbusy;
    st.e_lsb    = e[0];
    st.r1_zero  = (r1 == '0);
    st.r0_one   = (r0 == ONE);
    st.r_zero   = (r == '0);
    st.s_zero   = (s == '0);
    st.k_bad    = (k == '0) || (k >= cq);
    st.v_eq_r   = (v == r);
  end

  assign r_val = r;
  assign s_val = s;

endmodule
`default_nettype wire

[src/dsa_ctrl.sv]
// Controller: sequences exponentiations, inverses and checks over the datapath.
`default_nettype none
`include "assert_macros.svh"
module dsa_ctrl #(
  parameter int MOD_BITS = dsa_pkg::MOD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dsa_pkg::stat_t    st,
  output dsa_pkg::cmd_t          cmd,
  output dsa_pkg::outcome_t      code
);

  localparam int CW = $clog2(MOD_BITS);
  localparam logic [CW-1:0] LAST = CW'(MOD_BITS - 1);

  typedef enum logic [25:0] {
    S_IDLE    = 26'h0000001,
    S_PW_E    = 26'h0000002,
    S_PW_B    = 26'h0000004,
    S_PW_A    = 26'h0000008,
    S_PW_BIT  = 26'h0000010,
    S_PW_SQ   = 26'h0000020,
    S_PW_SH   = 26'h0000040,
    S_PW_RET  = 26'h0000080,
    S_R_RED   = 26'h0000100,
    S_CHK_R   = 26'h0000200,
    S_INV_T   = 26'h0000400,
    S_INV_M   = 26'h0000800,
    S_INV_S   = 26'h0001000,
    S_INV_END = 26'h0002000,
    S_S_XR    = 26'h0004000,
    S_S_HQ    = 26'h0008000,
    S_S_ADD   = 26'h0010000,
    S_S_MUL   = 26'h0020000,
    S_CHK_S   = 26'h0040000,
    S_U1      = 26'h0080000,
    S_U2      = 26'h0100000,
    S_V_MUL   = 26'h0200000,
    S_V_RED   = 26'h0400000,
    S_CMP     = 26'h0800000,
    S_FIN     = 26'h1000000,
    S_WAIT    = 26'h2000000
  } state_t;

  typedef enum logic [1:0] {
    J_GK,
    J_GX,
    J_GU1,
    J_YU2
  } job_t;

  state_t            state, state_next, ret, ret_next;
  job_t              job, job_next;
  logic              inv_s, inv_s_next;
  logic [CW-1:0]     cnt, cnt_next;
  dsa_pkg::outcome_t code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      job   <= J_GK;
      inv_s <= 1'b0;
      cnt   <= '0;
      code  <= dsa_pkg::OC_VALID;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      job   <= job_next;
      inv_s <= inv_s_next;
      cnt   <= cnt_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    job_next     = job;
    inv_s_next   = inv_s;
    cnt_next     = cnt;
    code_next    = code;
    cmd.op       = dsa_pkg::OP_NONE;
    cmd.a_sel    = dsa_pkg::SEL_ONE;
    cmd.b_sel    = dsa_pkg::SEL_ONE;
    cmd.m_q      = 1'b0;
    cmd.dst      = dsa_pkg::DST_ACC;
    cmd.fin      = 1'b0;
    cmd.in_ready = 1'b0;

    unique case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (st.in_valid) begin
          cmd.op     = dsa_pkg::OP_LOAD;
          job_next   = J_GK;
          state_next = S_PW_E;
        end
      end
      S_PW_E: begin
        cmd.op = dsa_pkg::OP_LDE;
        case (job)
          J_GK:    cmd.a_sel = dsa_pkg::SEL_K;
          J_GX:    cmd.a_sel = dsa_pkg::SEL_X;
          J_GU1:   cmd.a_sel = dsa_pkg::SEL_U1;
          default: cmd.a_sel = dsa_pkg::SEL_U2;
        endcase
        state_next = S_PW_B;
      end
      S_PW_B: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = (job == J_YU2) ? dsa_pkg::SEL_Y : dsa_pkg::SEL_G;
        cmd.dst    = dsa_pkg::DST_B;
        ret_next   = S_PW_A;
        state_next = S_WAIT;
      end
      S_PW_A: begin
        // 1 mod p, which is 0 when p is below 2.
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.dst    = dsa_pkg::DST_ACC;
        cnt_next   = '0;
        ret_next   = S_PW_BIT;
        state_next = S_WAIT;
      end
      S_PW_BIT: begin
        if (st.e_lsb) begin
          cmd.op     = dsa_pkg::OP_MUL;
          cmd.a_sel  = dsa_pkg::SEL_ACC;
          cmd.b_sel  = dsa_pkg::SEL_B;
          cmd.dst    = dsa_pkg::DST_ACC;
          ret_next   = S_PW_SQ;
          state_next = S_WAIT;
        end else begin
          state_next = S_PW_SQ;
        end
      end
      S_PW_SQ: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_B;
        cmd.b_sel  = dsa_pkg::SEL_B;
        cmd.dst    = dsa_pkg::DST_B;
        ret_next   = S_PW_SH;
        state_next = S_WAIT;
      end
      S_PW_SH: begin
        cmd.op = dsa_pkg::OP_SHE;
        if (cnt == LAST) begin
          state_next = S_PW_RET;
        end else begin
          cnt_next   = cnt + CW'(1);
          state_next = S_PW_BIT;
        end
      end
      S_PW_RET: begin
        case (job)
          J_GK: state_next = S_R_RED;
          J_GX: begin
            cmd.op     = dsa_pkg::OP_MVY;
            job_next   = J_GU1;
            state_next = S_PW_E;
          end
          J_GU1: begin
            cmd.op     = dsa_pkg::OP_MVV;
            job_next   = J_YU2;
            state_next = S_PW_E;
          end
          default: state_next = S_V_MUL;
        endcase
      end
      S_R_RED: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_ACC;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_R;
        ret_next   = S_CHK_R;
        state_next = S_WAIT;
      end
      S_CHK_R: begin
        if (st.r_zero) begin
          code_next  = dsa_pkg::OC_R_ZERO;
          state_next = S_FIN;
        end else if (st.k_bad) begin
          code_next  = dsa_pkg::OC_K_BAD;
          state_next = S_FIN;
        end else begin
          cmd.op     = dsa_pkg::OP_INV_INIT;
          cmd.a_sel  = dsa_pkg::SEL_K;
          inv_s_next = 1'b0;
          state_next = S_INV_T;
        end
      end
      S_INV_T: begin
        if (st.r1_zero) begin
          state_next = S_INV_END;
        end else begin
          cmd.op     = dsa_pkg::OP_DIV;
          ret_next   = S_INV_M;
          state_next = S_WAIT;
        end
      end
      S_INV_M: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_QT;
        cmd.b_sel  = dsa_pkg::SEL_T1;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_T;
        ret_next   = S_INV_S;
        state_next = S_WAIT;
      end
      S_INV_S: begin
        cmd.op     = dsa_pkg::OP_INV_STEP;
        state_next = S_INV_T;
      end
      S_INV_END: begin
        if (!st.r0_one) begin
          code_next  = inv_s ? dsa_pkg::OC_S_NOINV : dsa_pkg::OC_K_BAD;
          state_next = S_FIN;
        end else begin
          cmd.op     = dsa_pkg::OP_INV_END;
          state_next = inv_s ? S_U1 : S_S_XR;
        end
      end
      S_S_XR: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_X;
        cmd.b_sel  = dsa_pkg::SEL_R;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_T;
        ret_next   = S_S_HQ;
        state_next = S_WAIT;
      end
      S_S_HQ: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_H;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_S;
        ret_next   = S_S_ADD;
        state_next = S_WAIT;
      end
      S_S_ADD: begin
        cmd.op     = dsa_pkg::OP_ADD;
        state_next = S_S_MUL;
      end
      S_S_MUL: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_KI;
        cmd.b_sel  = dsa_pkg::SEL_S;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_S;
        ret_next   = S_CHK_S;
        state_next = S_WAIT;
      end
      S_CHK_S: begin
        if (st.s_zero) begin
          code_next  = dsa_pkg::OC_S_ZERO;
          state_next = S_FIN;
        end else begin
          cmd.op     = dsa_pkg::OP_INV_INIT;
          cmd.a_sel  = dsa_pkg::SEL_S;
          inv_s_next = 1'b1;
          state_next = S_INV_T;
        end
      end
      S_U1: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_H;
        cmd.b_sel  = dsa_pkg::SEL_KI;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_U1;
        ret_next   = S_U2;
        state_next = S_WAIT;
      end
      S_U2: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_R;
        cmd.b_sel  = dsa_pkg::SEL_KI;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_U2;
        job_next   = J_GX;
        ret_next   = S_PW_E;
        state_next = S_WAIT;
      end
      S_V_MUL: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_V;
        cmd.b_sel  = dsa_pkg::SEL_ACC;
        cmd.dst    = dsa_pkg::DST_V;
        ret_next   = S_V_RED;
        state_next = S_WAIT;
      end
      S_V_RED: begin
        cmd.op     = dsa_pkg::OP_MUL;
        cmd.a_sel  = dsa_pkg::SEL_V;
        cmd.m_q    = 1'b1;
        cmd.dst    = dsa_pkg::DST_V;
        ret_next   = S_CMP;
        state_next = S_WAIT;
      end
      S_CMP: begin
        code_next  = st.v_eq_r ? dsa_pkg::OC_VALID : dsa_pkg::OC_MISMATCH;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (st.out_free) begin
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!st.busy) begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  `DSA_ASSERT(a_start_when_free, (cmd.op == dsa_pkg::OP_MUL || cmd.op == dsa_pkg::OP_DIV) |-> !st.busy, "unit started while busy")
  `DSA_ASSERT(a_wait_sees_busy, (state != S_WAIT) ##1 (state == S_WAIT) |-> st.busy, "wait entered with idle units")
  `DSA_ASSERT_NEXT(a_wait_leaves, state == S_WAIT && !st.busy, state != S_WAIT, "wait not left after completion")

endmodule
`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the DSA sign and verify engine with a signature scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 50;
  localparam int FW             = dsa_pkg::FIELD_W;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [FW-1:0] cfg_data;

  dsa_in_if  in_ch ();
  dsa_out_if out_ch ();

  dsa_sign_verify_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned mod_red(longint unsigned a, longint unsigned m);
    return (m == 0) ? 0 : a % m;
  endfunction

  function automatic longint unsigned mod_pow(longint unsigned base, longint unsigned expo,
                                              longint unsigned m);
    longint unsigned acc;
    longint unsigned b;
    acc = mod_red(1, m);
    b = mod_red(base, m);
    for (int i = 0; i < 16; i++) begin
      if ((expo >> i) & 1) acc = mod_red(acc * b, m);
      b = mod_red(b * b, m);
    end
    return acc;
  endfunction

  // Extended Euclid; returns 0 when a has no inverse modulo m.
  function automatic bit mod_inv(longint unsigned a, longint unsigned m,
                                 output longint unsigned inv);
    longint r0, r1, t0, t1, qt, tmp;
    inv = 0;
    if (m < 2 || a == 0 || a >= m) return 1'b0;
    r0 = m;
    r1 = a;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      qt = r0 / r1;
      tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
      tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
    end
    if (r0 != 1) return 1'b0;
    if (t0 < 0) t0 += m;
    inv = t0;
    return 1'b1;
  endfunction

  typedef struct {
    logic [FW-1:0]      sig_r;
    logic [FW-1:0]      sig_s;
    dsa_pkg::outcome_t  outcome;
  } signature_t;

  class signature_scoreboard;
    longint unsigned p, q, g, x;
    signature_t pending_sigs[$];
    int mismatches;
    int checked;
    int outcome_seen[6];

    function new();
      p = dsa_pkg::P_RESET; q = dsa_pkg::Q_RESET;
      g = dsa_pkg::G_RESET; x = dsa_pkg::X_RESET;
      mismatches = 0;
      checked = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    function void set_reg(dsa_pkg::cfg_idx_t idx, logic [FW-1:0] val);
      case (idx)
        dsa_pkg::CFG_P: p = val;
        dsa_pkg::CFG_Q: q = val;
        dsa_pkg::CFG_G: g = val;
        dsa_pkg::CFG_X: x = val;
      endcase
    endfunction

    function signature_t sign_and_verify(longint unsigned h, longint unsigned k);
      signature_t res;
      longint unsigned r, s, kinv, w, u1, u2, y, v;
      r = mod_red(mod_pow(g, k, p), q);
      s = 0;
      if (r == 0) begin
        res.outcome = dsa_pkg::OC_R_ZERO;
        r = 0;
      end else if (!mod_inv(k, q, kinv)) begin
        res.outcome = dsa_pkg::OC_K_BAD;
      end else begin
        s = mod_red(kinv * mod_red(h + x * r, q), q);
        if (s == 0) begin
          res.outcome = dsa_pkg::OC_S_ZERO;
        end else if (!mod_inv(s, q, w)) begin
          res.outcome = dsa_pkg::OC_S_NOINV;
        end else begin
          u1 = mod_red(h * w, q);
          u2 = mod_red(r * w, q);
          y = mod_pow(g, x, p);
          v = mod_red(mod_red(mod_pow(g, u1, p) * mod_pow(y, u2, p), p), q);
          res.outcome = (v == r) ? dsa_pkg::OC_VALID : dsa_pkg::OC_MISMATCH;
        end
      end
      res.sig_r = r[FW-1:0];
      res.sig_s = s[FW-1:0];
      return res;
    endfunction

    function void note_request(logic [FW-1:0] h, logic [FW-1:0] k);
      pending_sigs.push_back(sign_and_verify(h, k));
    endfunction

    function void check_result(logic [FW-1:0] r, logic [FW-1:0] s,
                               logic [dsa_pkg::CODE_W-1:0] oc);
      signature_t exp_sig;
      if (pending_sigs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result r=%0d s=%0d outcome=%0d", r, s, oc);
        return;
      end
      exp_sig = pending_sigs.pop_front();
      checked++;
      if (exp_sig.outcome <= dsa_pkg::OC_S_NOINV) outcome_seen[exp_sig.outcome]++;
      if (r !== exp_sig.sig_r || s !== exp_sig.sig_s || oc !== exp_sig.outcome) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d expected r=%0d s=%0d outcome=%0d, got r=%0d s=%0d outcome=%0d",
                   checked, exp_sig.sig_r, exp_sig.sig_s, exp_sig.outcome, r, s, oc);
      end
    endfunction
  endclass

  signature_scoreboard sb;
  int idle_cycles;
  int sent;

  initial sb = new();

  // Both channels are sampled on the pre-edge values.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.message_hash, in_ch.nonce);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.sig_r, out_ch.sig_s, out_ch.outcome);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog expired with %0d results outstanding", sb.pending_sigs.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  function automatic int pick_gap(int long_max);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 8);
    return $urandom_range(9, long_max);
  endfunction

  // Receiver side: random stalls, with stretches of constant readiness.
  initial begin
    int hold;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 3000) : $urandom_range(1, 20);
      out_ch.ready <= 1'b1;
      repeat (hold) @(posedge clk);
      hold = pick_gap(4000);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  task automatic send_request(logic [FW-1:0] h, logic [FW-1:0] k);
    int gap;
    gap = pick_gap(3000);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.message_hash <= h;
    in_ch.nonce        <= k;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_sigs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(logic [FW-1:0] p, logic [FW-1:0] q,
                             logic [FW-1:0] g, logic [FW-1:0] x);
    logic [FW-1:0] vals[4];
    vals = '{p, q, g, x};
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[dsa_pkg::CFG_IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_reg(dsa_pkg::cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Most nonces are in range so that the full sign and verify path runs.
  task automatic random_requests(int count);
    logic [FW-1:0] h, k;
    for (int i = 0; i < count; i++) begin
      h = FW'($urandom());
      if (sb.q >= 2 && $urandom_range(0, 99) < 85) k = FW'($urandom_range(1, sb.q - 1));
      else k = FW'($urandom());
      send_request(h, k);
    end
  endtask

  // Hash that forces s to zero for the given nonce.
  function automatic logic [FW-1:0] zero_s_hash(longint unsigned k);
    longint unsigned r;
    r = mod_red(mod_pow(sb.g, k, sb.p), sb.q);
    return FW'(mod_red(sb.q - mod_red(sb.x * r, sb.q), sb.q));
  endfunction

  initial begin
    longint unsigned group_p[8];
    longint unsigned group_q[8];
    longint unsigned gp, gq, gg, base;
    int sel;
    group_p = '{23, 47, 59, 607, 1019, 7879, 43, 65423};
    group_q = '{11, 23, 29, 101, 509, 101, 21, 32711};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.message_hash = '0;
    in_ch.nonce = '0;
    sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed requests on the reset group.
    send_request(16'd0, 16'd1);
    send_request(16'hFFFF, 16'd10);
    send_request(16'd7, 16'd0);
    send_request(16'd7, 16'd11);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h5555, 16'd3);
    send_request(zero_s_hash(3), 16'd3);
    send_request(zero_s_hash(7), 16'd7);
    send_request(16'hAAAA, 16'd5);

    // Composite q leaves some s values without an inverse.
    load_config(16'd43, 16'd21, FW'(mod_pow(2, 2, 43)), 16'd5);
    for (int k = 1; k < 21; k++) send_request(FW'($urandom()), k[FW-1:0]);

    // Degenerate moduli reduce everything to zero; all-ones registers and g=1, x=0 follow.
    load_config(16'd0, 16'd11, 16'd5, 16'd6);
    send_request(16'd3, 16'd4);
    load_config(16'd1, 16'd11, 16'd5, 16'd6);
    send_request(16'd3, 16'd0);
    load_config(16'd23, 16'd0, 16'd5, 16'd6);
    send_request(16'd3, 16'd4);
    load_config(16'd23, 16'd1, 16'd5, 16'd6);
    send_request(16'd3, 16'd4);
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_requests(20);
    load_config(16'd23, 16'd11, 16'd1, 16'd0);
    random_requests(20);

    for (int ph = 0; ph < 12; ph++) begin
      sel = $urandom_range(0, 7);
      gp = group_p[sel];
      gq = group_q[sel];
      gg = 1;
      for (int t = 0; t < 8 && gg == 1; t++) begin
        base = $urandom_range(2, gp - 1);
        gg = mod_pow(base, (gp - 1) / gq, gp);
      end
      if (ph % 4 == 3) load_config(FW'($urandom()), FW'($urandom()), FW'($urandom()),
                                   FW'($urandom()));
      else load_config(FW'(gp), FW'(gq), FW'(gg), FW'($urandom()));
      random_requests(130);
    end

    wait_idle();
    $display("Sent %0d requests over 20 register settings; %0d signatures checked.",
             sent, sb.checked);
    $display("Outcomes: valid %0d, mismatch %0d, r zero %0d, bad nonce %0d, s zero %0d, s noinv %0d",
             sb.outcome_seen[0], sb.outcome_seen[1], sb.outcome_seen[2],
             sb.outcome_seen[3], sb.outcome_seen[4], sb.outcome_seen[5]);
    if (sb.mismatches == 0 && sb.pending_sigs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_sigs.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire
